// ===== rtl/mrc_pkg.sv =====
package mrc_pkg;

	localparam int MAX_FRAME = 256;
	localparam int MAX_REGS = 125;
	localparam int MAX_COIL_BITS = 2000;
	localparam int MIN_LEN = 5;
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [1:0] KIND_REG = 2'd0;
	localparam logic [1:0] KIND_COIL = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_BAD_CRC = 2'd2;
	localparam logic [1:0] ST_EXCEPTION = 2'd3;

	localparam logic [1:0] MODE_ECHO = 2'd0;
	localparam logic [1:0] MODE_REG = 2'd1;
	localparam logic [1:0] MODE_COIL = 2'd2;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [10:0] expected_quantity;
	} in_t;

	typedef struct packed {
		logic [1:0]  item_kind;
		logic [10:0] element_index;
		logic [15:0] element_value;
		logic [1:0]  status_code;
		logic [7:0]  slave_id;
		logic [7:0]  func_code;
		logic [7:0]  exc_code;
		logic        last_item;
	} out_t;

	// One queue entry: an optional data job (a register or a run of coil bits)
	// followed by an optional status item.
	typedef struct packed {
		logic        has_data;
		logic        is_coil;
		logic [15:0] value;
		logic [10:0] index;
		logic [3:0]  ncoil;
		logic [7:0]  sid;
		logic [7:0]  fc;
		logic        has_status;
		logic [1:0]  st;
		logic [7:0]  ssid;
		logic [7:0]  sfc;
		logic [7:0]  exc;
	} job_t;

	function automatic logic [15:0] crc_byte(logic [15:0] c_in, logic [7:0] b);
		logic [15:0] c;
		c = c_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/mrc_front.sv =====
module mrc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  mrc_pkg::in_t      in_item,
	output logic              job_push,
	output mrc_pkg::job_t     job
);

	logic [8:0]  pos_q, pos_n;
	logic [15:0] crc_q, crc_n;
	logic [7:0]  d0_q, d0_n, d1_q, d1_n;
	logic [1:0]  mode_q, mode_n;
	logic [10:0] qty_q, qty_n;
	logic [7:0]  h0_q, h0_n, h1_q, h1_n, h2_q, h2_n;
	logic [7:0]  hold_q, hold_n;
	logic [10:0] cnt_q, cnt_n;
	logic        ovf_q, ovf_n;

	logic [8:0]  q;
	logic [8:0]  d;
	logic [6:0]  rcap;
	logic [10:0] ccap;
	logic [10:0] rem;
	logic [3:0]  nc;

	always_comb begin
		mode_n = mode_q;
		qty_n = qty_q;
		crc_n = crc_q;
		d0_n = d0_q;
		d1_n = d1_q;
		h0_n = h0_q;
		h1_n = h1_q;
		h2_n = h2_q;
		hold_n = hold_q;
		cnt_n = cnt_q;
		ovf_n = ovf_q;
		pos_n = pos_q;
		job = '0;
		q = pos_q - 9'd2;
		d = q - 9'd3;
		rcap = (h2_q[7:1] > 7'(mrc_pkg::MAX_REGS)) ? 7'(mrc_pkg::MAX_REGS) : h2_q[7:1];
		ccap = 11'd0;
		rem = 11'd0;
		nc = 4'd0;

		if (pos_q == 9'd0 && !ovf_q) begin
			mode_n = (in_item.cmd == 2'd3) ? mrc_pkg::MODE_ECHO : in_item.cmd;
			qty_n = in_item.expected_quantity;
		end
		ccap = (qty_n > 11'(mrc_pkg::MAX_COIL_BITS)) ? 11'(mrc_pkg::MAX_COIL_BITS) : qty_n;

		if (ovf_q || {1'b0, pos_q} >= 10'(mrc_pkg::MAX_FRAME)) begin
			ovf_n = 1'b1;
		end else begin
			if (pos_q >= 9'd2) begin
				crc_n = mrc_pkg::crc_byte(crc_q, d0_q);
				if (q < 9'd3) begin
					unique case (q[1:0])
						2'd0: h0_n = d0_q;
						2'd1: h1_n = d0_q;
						default: h2_n = d0_q;
					endcase
				end else if (!h1_q[7] && d < {1'b0, h2_q}) begin
					job.sid = h0_q;
					job.fc = h1_q;
					job.index = cnt_q;
					if (mode_n == mrc_pkg::MODE_REG) begin
						if (!d[0]) begin
							hold_n = d0_q;
						end else if (cnt_q < {4'd0, rcap}) begin
							job.has_data = 1'b1;
							job.value = {hold_q, d0_q};
							cnt_n = cnt_q + 11'd1;
						end
					end else if (mode_n == mrc_pkg::MODE_COIL) begin
						if (cnt_q < ccap) begin
							rem = ccap - cnt_q;
							nc = (rem >= 11'd8) ? 4'd8 : rem[3:0];
							job.has_data = 1'b1;
							job.is_coil = 1'b1;
							job.ncoil = nc;
							job.value = {8'd0, d0_q};
							cnt_n = cnt_q + {7'd0, nc};
						end
					end
				end
			end
			d0_n = d1_q;
			d1_n = in_item.data_byte;
			pos_n = pos_q + 9'd1;
		end

		if (in_item.last_byte) begin
			job.has_status = 1'b1;
			if (pos_n < 9'(mrc_pkg::MIN_LEN) || ovf_n) begin
				job.st = mrc_pkg::ST_INVALID;
			end else if ({d1_n, d0_n} != crc_n) begin
				job.st = mrc_pkg::ST_BAD_CRC;
			end else begin
				job.ssid = h0_n;
				job.sfc = h1_n;
				if (h1_n[7]) begin
					job.st = mrc_pkg::ST_EXCEPTION;
					job.exc = h2_n;
				end else if (mode_n != mrc_pkg::MODE_ECHO) begin
					if ({2'd0, h2_n} + 10'(mrc_pkg::MIN_LEN) != {1'b0, pos_n}) begin
						job.st = mrc_pkg::ST_INVALID;
					end else if (mode_n == mrc_pkg::MODE_REG) begin
						if ((h2_n[7:1] > 7'(mrc_pkg::MAX_REGS) ? 11'(mrc_pkg::MAX_REGS)
								: {4'd0, h2_n[7:1]}) != qty_n) begin
							job.st = mrc_pkg::ST_INVALID;
						end
					end
				end
			end
		end

		job_push = accept && (job.has_data || job.has_status);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			crc_q <= mrc_pkg::CRC_INIT;
			d0_q <= '0;
			d1_q <= '0;
			mode_q <= mrc_pkg::MODE_ECHO;
			qty_q <= '0;
			h0_q <= '0;
			h1_q <= '0;
			h2_q <= '0;
			hold_q <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (accept) begin
			if (in_item.last_byte) begin
				pos_q <= '0;
				crc_q <= mrc_pkg::CRC_INIT;
				d0_q <= '0;
				d1_q <= '0;
				mode_q <= mrc_pkg::MODE_ECHO;
				qty_q <= '0;
				h0_q <= '0;
				h1_q <= '0;
				h2_q <= '0;
				hold_q <= '0;
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				pos_q <= pos_n;
				crc_q <= crc_n;
				d0_q <= d0_n;
				d1_q <= d1_n;
				mode_q <= mode_n;
				qty_q <= qty_n;
				h0_q <= h0_n;
				h1_q <= h1_n;
				h2_q <= h2_n;
				hold_q <= hold_n;
				cnt_q <= cnt_n;
				ovf_q <= ovf_n;
			end
		end
	end

endmodule

// ===== rtl/mrc_queue.sv =====
module mrc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mrc_pkg::job_t wdata,
	output logic          full,
	input  logic          pop,
	output logic          valid,
	output mrc_pkg::job_t rdata
);

	mrc_pkg::job_t mem_q [mrc_pkg::QDEPTH];
	logic [mrc_pkg::QAW-1:0] wp_q, rp_q;
	logic [mrc_pkg::QAW:0]   cnt_q;

	assign full = (cnt_q == (mrc_pkg::QAW+1)'(mrc_pkg::QDEPTH));
	assign valid = (cnt_q != '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid)
		else $error("queue read while empty");
	a_count_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count did not advance");

endmodule

// ===== rtl/mrc_back.sv =====
module mrc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	input  mrc_pkg::job_t job,
	output logic          job_pop,
	output logic          empty,
	input  logic          pop,
	output mrc_pkg::out_t out_item
);

	logic [3:0]    sub_q;
	logic [3:0]    ndata;
	logic [3:0]    total;
	logic          load;
	mrc_pkg::out_t nxt;
	mrc_pkg::out_t out_q;
	logic          out_v_q;

	assign ndata = job.has_data ? (job.is_coil ? job.ncoil : 4'd1) : 4'd0;
	assign total = ndata + {3'd0, job.has_status};
	assign load = job_valid && (!out_v_q || pop);
	assign job_pop = load && (sub_q + 4'd1 == total);
	assign empty = !out_v_q;
	assign out_item = out_q;

	always_comb begin
		nxt = '0;
		if (sub_q < ndata) begin
			nxt.slave_id = job.sid;
			nxt.func_code = job.fc;
			if (job.is_coil) begin
				nxt.item_kind = mrc_pkg::KIND_COIL;
				nxt.element_index = job.index + {7'd0, sub_q};
				nxt.element_value = {15'd0, job.value[sub_q[2:0]]};
			end else begin
				nxt.item_kind = mrc_pkg::KIND_REG;
				nxt.element_index = job.index;
				nxt.element_value = job.value;
			end
		end else begin
			nxt.item_kind = mrc_pkg::KIND_STATUS;
			nxt.status_code = job.st;
			nxt.slave_id = job.ssid;
			nxt.func_code = job.sfc;
			nxt.exc_code = job.exc;
			nxt.last_item = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (load) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
			if (job_pop) begin
				sub_q <= '0;
			end else if (load) begin
				sub_q <= sub_q + 4'd1;
			end
		end
	end

	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (out_item.last_item == (out_item.item_kind == mrc_pkg::KIND_STATUS)))
		else $error("last marker on a data item");
	a_data_no_status: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_item.item_kind != mrc_pkg::KIND_STATUS) |-> out_item.status_code == '0)
		else $error("status code on a data item");
	a_coil_one_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_item.item_kind == mrc_pkg::KIND_COIL) |-> out_item.element_value[15:1] == '0)
		else $error("coil value wider than one bit");

endmodule

// ===== rtl/modbus_rtu_response_checker_unit.sv =====
// Modbus RTU response checker.
// Input channel: one frame byte per item (push/full), with cmd and
// expected_quantity sampled on the first byte of a frame and last_byte on the
// final one. An item is taken whenever full is low.
// Result channel (empty/pop): register values, coil bits and one closing status
// item per frame, in frame order. Data items are released two bytes after
// their byte arrives, once that byte is known not to be part of the CRC.
// Ordering: a result reaches the result ports through the queue and then the
// result register once the byte that releases it is accepted, and waits
// behind any earlier result still in line.
// Throughput: the front takes one byte per cycle while full is low; the result
// stage issues one item per cycle while the receiver pops, so a coil byte gives
// up to eight items, a closing coil byte up to nine; that stage sets the rate.
// A four-entry queue separates the two sides, so bytes keep flowing while
// coil bits drain. When the receiver stalls, the queue fills and full rises.
// Reset clears all frame state, the queue and the result valid flag; no item
// is pending afterwards.
module modbus_rtu_response_checker_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  mrc_pkg::in_t  in_item,
	output logic          empty,
	input  logic          pop,
	output mrc_pkg::out_t out_item
);

	logic          accept;
	logic          q_push;
	logic          q_pop;
	logic          q_valid;
	mrc_pkg::job_t q_wdata;
	mrc_pkg::job_t q_rdata;

	assign accept = push && !full;

	mrc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_item  (in_item),
		.job_push (q_push),
		.job      (q_wdata)
	);

	mrc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (full),
		.pop    (q_pop),
		.valid  (q_valid),
		.rdata  (q_rdata)
	);

	mrc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_valid),
		.job       (q_rdata),
		.job_pop   (q_pop),
		.empty     (empty),
		.pop       (pop),
		.out_item  (out_item)
	);

endmodule
